>>> rtl/core/dlt_pkg.sv
// shared types and opcodes for the device liveness table
`timescale 1ns / 1ps

package dlt_pkg;

    localparam int MAX_DEVICES_DEF = 16;

    localparam int OP_W    = 3;
    localparam int TYPE_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int ACT_W   = 8;
    localparam int COUNT_W = 5;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND     = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK_INC = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK_CLR = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR_ALL  = 3'd5;
    localparam logic [OP_W-1:0] OP_PURGE    = 3'd6;
    localparam logic [OP_W-1:0] OP_COUNT    = 3'd7;

    // command token that walks the row of cells
    typedef struct packed {
        logic              valid;
        logic [OP_W-1:0]   op;
        logic [TYPE_W-1:0] dev_type;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              claimed;
    } tok_t;

    // end-of-command broadcast to every cell
    typedef struct packed {
        logic apply;
        logic commit;
    } cmt_t;

endpackage

>>> rtl/core/dlt_cell.sv
// one table entry with its key compare, update and token hand-off
`timescale 1ns / 1ps

module dlt_cell #(
    parameter int CNT_W = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dlt_pkg::tok_t     tok_in,
    input  logic [CNT_W-1:0]  cnt_in,
    input  dlt_pkg::cmt_t     cmt,
    output dlt_pkg::tok_t     tok_out,
    output logic [CNT_W-1:0]  cnt_out
);
    import dlt_pkg::*;

    logic              valid_reg, valid_next;
    logic              pend_reg, pend_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    tok_t              tok_reg, tok_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic match;
    logic claim;

    assign match = valid_reg && (type_reg == tok_in.dev_type) && (addr_reg == tok_in.addr);

    always_comb begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        type_next  = type_reg;
        addr_next  = addr_reg;
        act_next   = act_reg;
        tok_next   = tok_in;
        claim      = 1'b0;

        if (tok_in.valid) begin
            case (tok_in.op)
                OP_INSERT: begin
                    tok_next.hit = tok_in.hit | match;
                    if (!valid_reg && !tok_in.claimed) begin
                        claim            = 1'b1;
                        pend_next        = 1'b1;
                        type_next        = tok_in.dev_type;
                        addr_next        = tok_in.addr;
                        act_next         = ACT_W'(1);
                        tok_next.claimed = 1'b1;
                    end
                end
                OP_REMOVE: begin
                    tok_next.hit = tok_in.hit | match;
                    if (match) begin
                        valid_next = 1'b0;
                    end
                end
                OP_FIND: begin
                    tok_next.hit = tok_in.hit | match;
                end
                OP_TICK_INC: begin
                    tok_next.hit = tok_in.hit | match;
                    if (match) begin
                        act_next = act_reg + ACT_W'(1);
                    end
                end
                OP_TICK_CLR: begin
                    tok_next.hit = tok_in.hit | match;
                    if (match) begin
                        act_next = '0;
                    end
                end
                OP_CLR_ALL: begin
                    if (valid_reg) begin
                        act_next = '0;
                    end
                end
                OP_PURGE: begin
                    if (valid_reg && (act_reg == '0)) begin
                        valid_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        cnt_next = cnt_in + CNT_W'(valid_next | claim);

        // insert outcome settled once the token has left the row
        if (cmt.apply) begin
            pend_next = 1'b0;
            if (cmt.commit && pend_reg) begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        addr_reg <= addr_next;
        act_reg  <= act_next;
        cnt_reg  <= cnt_next;
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

>>> rtl/core/device_liveness_table_core.sv
// top level of the device liveness table: command intake, row of cells, result register
`timescale 1ns / 1ps

// Each command travels the row of MAX_DEVICES cells as a token, one cell per
// clock, from the intake register through the cells to the finished-token
// register, and one command is in the row at a time. The next command is taken
// as soon as the previous result is loaded into the output register, even while
// that result still waits. An insert parks its key in the lowest free cell on the
// way and is committed or dropped when its result is loaded into the output
// register, depending on whether the key was found elsewhere in the row.
module device_liveness_table_core #(
    parameter int MAX_DEVICES = dlt_pkg::MAX_DEVICES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[2:0], dev_kind[4:3], short_addr[20:5], zero fill
    input  logic [dlt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok[0], entry_count[5:1], zero fill
    output logic [dlt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dlt_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEVICES + 1);

    tok_t              link_tok [MAX_DEVICES+1];
    logic [CNT_W-1:0]  link_cnt [MAX_DEVICES+1];
    cmt_t              cmt;

    logic              busy_reg, busy_next;
    tok_t              tok_reg, tok_next;
    tok_t              fin_reg, fin_next;
    logic [CNT_W-1:0]  fin_cnt_reg, fin_cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [COUNT_W-1:0] m_cnt_reg, m_cnt_next;

    logic              s_accept;
    logic              release_fin;
    logic              ok_fin;
    logic [CNT_W-1:0]  cnt_fin;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;

    assign link_tok[0] = tok_reg;
    assign link_cnt[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DEVICES; gi++) begin : g_cell
            dlt_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (link_tok[gi]),
                .cnt_in  (link_cnt[gi]),
                .cmt     (cmt),
                .tok_out (link_tok[gi+1]),
                .cnt_out (link_cnt[gi+1])
            );
        end
    endgenerate

    assign release_fin = fin_reg.valid && (!m_valid_reg || m_tready);
    assign cmt.apply   = release_fin;
    assign cmt.commit  = release_fin && (fin_reg.op == OP_INSERT)
                         && fin_reg.claimed && !fin_reg.hit;

    always_comb begin
        case (fin_reg.op)
            OP_INSERT:   ok_fin = fin_reg.hit | fin_reg.claimed;
            OP_REMOVE:   ok_fin = fin_reg.hit;
            OP_FIND:     ok_fin = fin_reg.hit;
            OP_TICK_INC: ok_fin = fin_reg.hit;
            OP_TICK_CLR: ok_fin = fin_reg.hit;
            default:     ok_fin = 1'b1;
        endcase
    end

    // a parked insert slot was counted on the way; drop it when the key already existed
    assign cnt_fin = fin_cnt_reg - CNT_W'((fin_reg.op == OP_INSERT)
                                          && fin_reg.hit && fin_reg.claimed);
    assign cnt_ext = {{COUNT_W{1'b0}}, cnt_fin};

    always_comb begin
        tok_next          = '0;
        tok_next.valid    = s_accept;
        tok_next.op       = s_tdata[OP_W-1:0];
        tok_next.dev_type = s_tdata[OP_W +: TYPE_W];
        tok_next.addr     = s_tdata[OP_W+TYPE_W +: ADDR_W];

        busy_next    = busy_reg;
        fin_next     = fin_reg;
        fin_cnt_next = fin_cnt_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_cnt_next   = m_cnt_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (release_fin) begin
            m_valid_next   = 1'b1;
            m_ok_next      = ok_fin;
            m_cnt_next     = cnt_ext[COUNT_W-1:0];
            fin_next.valid = 1'b0;
            busy_next      = 1'b0;
        end
        if (link_tok[MAX_DEVICES].valid) begin
            fin_next     = link_tok[MAX_DEVICES];
            fin_cnt_next = link_cnt[MAX_DEVICES];
        end
        if (s_accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            tok_reg     <= '0;
            fin_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            tok_reg     <= tok_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_cnt_reg <= fin_cnt_next;
        m_ok_reg    <= m_ok_next;
        m_cnt_reg   <= m_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W-1){1'b0}}, m_cnt_reg, m_ok_reg};

endmodule

>>> tb/tb_top.sv
// testbench for the device liveness table: directed and random commands checked against a table tracker
`timescale 1ns / 1ps

module tb_top;
    import dlt_pkg::*;

    localparam int TABLE_SLOTS   = MAX_DEVICES_DEF;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int POOL_SIZE     = 20;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int LONG_HOLD     = 400;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] entry_count;
    } reply_t;

    class table_tracker;
        bit                slot_used[TABLE_SLOTS];
        logic [TYPE_W-1:0] slot_kind[TABLE_SLOTS];
        logic [ADDR_W-1:0] slot_addr[TABLE_SLOTS];
        logic [ACT_W-1:0]  slot_activity[TABLE_SLOTS];
        reply_t            replies_due[$];
        int                mismatches;
        int                replies_checked;
        int                op_seen[8];
        int                key_misses;
        int                full_rejects;
        int                wraps;
        int                peak_fill;

        task report(string what);
            if (mismatches < 50)
                $display("ERROR at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // applies one accepted transaction to the tracked table, queues its reply
        function void note_command(logic [OP_W-1:0] op, logic [TYPE_W-1:0] kind,
                                   logic [ADDR_W-1:0] addr);
            int     hit;
            int     free_slot;
            int     filled;
            reply_t r;
            hit = -1;
            free_slot = -1;
            filled = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i] && slot_kind[i] == kind && slot_addr[i] == addr && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
            r.ok = 1'b1;
            case (op)
                OP_INSERT: begin
                    if (hit < 0) begin
                        if (free_slot < 0) begin
                            r.ok = 1'b0;
                            full_rejects++;
                        end else begin
                            slot_used[free_slot]     = 1'b1;
                            slot_kind[free_slot]     = kind;
                            slot_addr[free_slot]     = addr;
                            slot_activity[free_slot] = 8'd1;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) slot_used[hit] = 1'b0;
                    else r.ok = 1'b0;
                end
                OP_FIND: begin
                    r.ok = (hit >= 0);
                end
                OP_TICK_INC: begin
                    if (hit >= 0) begin
                        if (slot_activity[hit] == 8'hFF) wraps++;
                        slot_activity[hit] = slot_activity[hit] + 8'd1;
                    end else begin
                        r.ok = 1'b0;
                    end
                end
                OP_TICK_CLR: begin
                    if (hit >= 0) slot_activity[hit] = '0;
                    else r.ok = 1'b0;
                end
                OP_CLR_ALL: begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (slot_used[i]) slot_activity[i] = '0;
                end
                OP_PURGE: begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (slot_used[i] && slot_activity[i] == '0) slot_used[i] = 1'b0;
                end
                default: ;
            endcase
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_used[i]) filled++;
            if (filled > peak_fill) peak_fill = filled;
            if (!r.ok && op != OP_INSERT) key_misses++;
            r.entry_count = filled[COUNT_W-1:0];
            op_seen[op]++;
            replies_due.push_back(r);
        endfunction

        task check_reply(logic ok, logic [COUNT_W-1:0] cnt);
            reply_t want;
            if (replies_due.size() == 0) begin
                report($sformatf("reply ok=%0b count=%0d with no command outstanding", ok, cnt));
                return;
            end
            want = replies_due.pop_front();
            replies_checked++;
            if (ok !== want.ok)
                report($sformatf("reply %0d: ok %0b, expected %0b",
                                 replies_checked, ok, want.ok));
            if (cnt !== want.entry_count)
                report($sformatf("reply %0d: entry_count %0d, expected %0d",
                                 replies_checked, cnt, want.entry_count));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    table_tracker      tracker;
    bit                idle_free;
    bit                held_long;
    int                commands_sent;
    logic [TYPE_W-1:0] pool_kind[POOL_SIZE];
    logic [ADDR_W-1:0] pool_addr[POOL_SIZE];

    device_liveness_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("timeout");
        $display("device_liveness_table_core: mismatch");
        $finish;
    end

    // offers one command and waits for its transaction
    task automatic issue_command(logic [OP_W-1:0] op, logic [TYPE_W-1:0] kind,
                                 logic [ADDR_W-1:0] addr);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, addr, kind, op};
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, kind, addr);
        commands_sent++;
    endtask

    task automatic run_directed();
        issue_command(OP_COUNT,    2'd0, 16'h0000);
        issue_command(OP_FIND,     2'd0, 16'h0000);
        issue_command(OP_REMOVE,   2'd0, 16'h0000);
        issue_command(OP_TICK_INC, 2'd3, 16'hFFFF);
        issue_command(OP_TICK_CLR, 2'd3, 16'hFFFF);
        issue_command(OP_INSERT,   2'd0, 16'h0000);
        issue_command(OP_INSERT,   2'd3, 16'hFFFF);
        issue_command(OP_INSERT,   2'd1, 16'h0000);
        issue_command(OP_INSERT,   2'd0, 16'h0000);
        issue_command(OP_FIND,     2'd3, 16'hFFFF);
        issue_command(OP_FIND,     2'd2, 16'hFFFF);
        issue_command(OP_TICK_INC, 2'd3, 16'hFFFF);
        issue_command(OP_TICK_CLR, 2'd0, 16'h0000);
        issue_command(OP_PURGE,    2'd2, 16'h5A5A);
        issue_command(OP_FIND,     2'd0, 16'h0000);
        issue_command(OP_COUNT,    2'd3, 16'hFFFF);
        issue_command(OP_CLR_ALL,  2'd3, 16'hA5A5);
        issue_command(OP_PURGE,    2'd0, 16'h0000);
        issue_command(OP_INSERT,   2'd2, 16'h1234);
        issue_command(OP_REMOVE,   2'd2, 16'h1234);
        issue_command(OP_REMOVE,   2'd2, 16'h1234);
        issue_command(OP_COUNT,    2'd1, 16'h8001);
    endtask

    // fills every slot, then tries a new key and a present key on the full table
    task automatic fill_to_capacity();
        logic [TYPE_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        issue_command(OP_CLR_ALL, 2'd0, 16'h0000);
        issue_command(OP_PURGE,   2'd0, 16'h0000);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            kind = TYPE_W'($urandom_range(0, 3));
            addr = {12'($urandom_range(0, 4095)), i[3:0]};
            issue_command(OP_INSERT, kind, addr);
        end
        issue_command(OP_INSERT, 2'd1, 16'hBEEF);
        issue_command(OP_INSERT, kind, addr);
        issue_command(OP_FIND,   kind, addr);
        issue_command(OP_TICK_INC, kind, addr);
        issue_command(OP_REMOVE, kind, addr);
        issue_command(OP_INSERT, 2'd1, 16'hBEEF);
        issue_command(OP_CLR_ALL, 2'd2, 16'h7777);
        issue_command(OP_PURGE,   2'd1, 16'h0001);
    endtask

    // walks one activity count through the wrap, then purges it
    task automatic wrap_activity();
        issue_command(OP_INSERT, 2'd2, 16'h5AA5);
        repeat (255) issue_command(OP_TICK_INC, 2'd2, 16'h5AA5);
        issue_command(OP_FIND,  2'd2, 16'h5AA5);
        issue_command(OP_PURGE, 2'd0, 16'h0000);
        issue_command(OP_FIND,  2'd2, 16'h5AA5);
    endtask

    task automatic random_pool_op();
        int                pick;
        int                w;
        logic [OP_W-1:0]   op;
        pick = $urandom_range(0, POOL_SIZE - 1);
        w = $urandom_range(0, 99);
        if (w < 30)      op = OP_INSERT;
        else if (w < 42) op = OP_REMOVE;
        else if (w < 57) op = OP_FIND;
        else if (w < 77) op = OP_TICK_INC;
        else if (w < 85) op = OP_TICK_CLR;
        else if (w < 88) op = OP_CLR_ALL;
        else if (w < 93) op = OP_PURGE;
        else             op = OP_COUNT;
        issue_command(op, pool_kind[pick], pool_addr[pick]);
    endtask

    task automatic run_random();
        int first;
        int seq;
        int pick;
        bit wrapped;
        first = commands_sent;
        wrapped = 1'b0;
        while (commands_sent < first + RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) idle_free = ~idle_free;
            if (!wrapped && commands_sent > first + 500) begin
                wrap_activity();
                wrapped = 1'b1;
            end
            seq = $urandom_range(0, 99);
            pick = $urandom_range(0, POOL_SIZE - 1);
            if (seq < 60) begin
                random_pool_op();
            end else if (seq < 70) begin
                // noise: any opcode, any key; sometimes refresh a pool key
                issue_command(OP_W'($urandom_range(0, 7)), TYPE_W'($urandom_range(0, 3)),
                              ADDR_W'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    pool_kind[pick] = TYPE_W'($urandom_range(0, 3));
                    pool_addr[pick] = ADDR_W'($urandom);
                end
            end else if (seq < 85) begin
                repeat ($urandom_range(6, 20)) begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    issue_command(OP_INSERT, pool_kind[pick], pool_addr[pick]);
                end
            end else if (seq < 95) begin
                issue_command(OP_INSERT, pool_kind[pick], pool_addr[pick]);
                repeat ($urandom_range(0, 5))
                    issue_command(OP_TICK_INC, pool_kind[pick], pool_addr[pick]);
                issue_command(OP_FIND, pool_kind[pick], pool_addr[pick]);
                if ($urandom_range(0, 1))
                    issue_command(OP_TICK_CLR, pool_kind[pick], pool_addr[pick]);
                issue_command(OP_REMOVE, pool_kind[pick], pool_addr[pick]);
            end else begin
                issue_command(OP_CLR_ALL, TYPE_W'($urandom_range(0, 3)), ADDR_W'($urandom));
                issue_command(OP_PURGE, TYPE_W'($urandom_range(0, 3)), ADDR_W'($urandom));
                issue_command(OP_COUNT, TYPE_W'($urandom_range(0, 3)), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin : reply_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_free ? 0 : $urandom_range(0, 16);
            if (!held_long && tracker.replies_checked >= 300) begin
                stall = LONG_HOLD;
                held_long = 1'b1;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_reply(m_tdata[0], m_tdata[COUNT_W:1]);
        end
    end

    initial begin : command_source
        int waited;
        tracker = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_kind[i] = (i < 4) ? i[1:0] : TYPE_W'($urandom_range(0, 3));
            pool_addr[i] = (i < 4) ? 16'h0000 : ADDR_W'($urandom);
        end
        pool_kind[4] = 2'd0;
        pool_addr[4] = 16'hFFFF;
        pool_kind[5] = 2'd3;
        pool_addr[5] = 16'hFFFF;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        fill_to_capacity();
        run_random();
        s_tvalid <= 1'b0;

        waited = 0;
        while (tracker.replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TABLE_SLOTS + 8) @(posedge aclk);
        if (tracker.replies_due.size() != 0)
            tracker.report($sformatf("%0d replies never arrived", tracker.replies_due.size()));

        $display("ran %0d commands: insert %0d remove %0d find %0d tick+ %0d tick0 %0d",
                 commands_sent, tracker.op_seen[OP_INSERT], tracker.op_seen[OP_REMOVE],
                 tracker.op_seen[OP_FIND], tracker.op_seen[OP_TICK_INC],
                 tracker.op_seen[OP_TICK_CLR]);
        $display("clear-all %0d purge %0d count %0d; %0d misses, %0d full rejects, %0d wraps, %s",
                 tracker.op_seen[OP_CLR_ALL], tracker.op_seen[OP_PURGE],
                 tracker.op_seen[OP_COUNT], tracker.key_misses, tracker.full_rejects,
                 tracker.wraps, held_long ? "output back-pressure seen" : "no long hold");
        if (tracker.mismatches == 0) begin
            $display("device_liveness_table_core: match");
        end else begin
            $display("device_liveness_table_core: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dlt_pkg.sv
rtl/core/dlt_cell.sv
rtl/core/device_liveness_table_core.sv
tb/tb_top.sv
